/* hw/rtl/rtc_cal_pkg.sv */
// Shared types and constants for the real-time clock calendar counter.
package rtc_cal_pkg;

   // Opcodes carried by each request beat
   localparam logic [1:0] OP_TICK        = 2'd0;
   localparam logic [1:0] OP_SET_TIME    = 2'd1;
   localparam logic [1:0] OP_SET_DATE    = 2'd2;
   localparam logic [1:0] OP_SET_ELAPSED = 2'd3;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESCALE_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EDIT_HOLD      = 1'd1;

   localparam logic [7:0] PRESCALE_LIMIT_RESET = 8'd125;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  first_value;
      logic [7:0]  second_value;
      logic [7:0]  third_value;
      logic [15:0] year_value;
      logic [31:0] elapsed_value;
   } req_type;

   typedef struct packed {
      logic [5:0]  cur_seconds;
      logic [5:0]  cur_minutes;
      logic [4:0]  cur_hours;
      logic [4:0]  cur_day;
      logic [3:0]  cur_month;
      logic [15:0] cur_year;
      logic        second_pulse;
      logic        minute_pulse;
      logic        hour_pulse;
      logic [31:0] total_ticks;
      logic [31:0] elapsed_ticks;
      logic        accepted;
   } rsp_type;

   typedef struct packed {
      logic [7:0] prescale_limit;
      logic       edit_hold;
   } cfg_type;

endpackage

/* hw/rtl/rtc_calendar_counter.sv */
// Real-time clock calendar counter: request and response registers, CSRs, core.
// One request beat per clock, one response beat per request. A beat is registered
// on entry, and the calendar update (prescaler, counters, time/date roll with leap
// years, validated writes) is combinational between that register and the
// response register, which drives rsp_valid. Throughput is one beat per cycle
// while rsp_ready is high; while a finished response waits, one more request is
// still taken into the input register, then req_ready drops until the response
// goes out. CSR writes take effect at once and are meant for idle periods.
module rtc_calendar_counter (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  rtc_cal_pkg::req_type                      req_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output rtc_cal_pkg::rsp_type                      rsp_data,
   input  logic                                      csr_wr_en,
   input  logic [rtc_cal_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [rtc_cal_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import rtc_cal_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type core_rsp;
   cfg_type cfg_ff, cfg_in;
   logic    advance;
   logic    take;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PRESCALE_LIMIT: cfg_in.prescale_limit = csr_wdata;
            CSR_EDIT_HOLD:      cfg_in.edit_hold      = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
         cfg_ff.prescale_limit <= PRESCALE_LIMIT_RESET;
         cfg_ff.edit_hold      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= core_rsp;
      end
   end

   rtc_cal_core u_core (
      .clock (clock),
      .reset (reset),
      .go    (advance),
      .req   (in_data_ff),
      .cfg   (cfg_ff),
      .rsp   (core_rsp)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* hw/rtl/rtc_cal_core.sv */
// Calendar state registers and the combinational update for one request beat.
module rtc_cal_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  rtc_cal_pkg::req_type req,
   input  rtc_cal_pkg::cfg_type cfg,
   output rtc_cal_pkg::rsp_type rsp
);
   import rtc_cal_pkg::*;

   logic [7:0]  prescale_ff, prescale_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic [4:0]  day_ff, day_in;
   logic [3:0]  month_ff, month_in;
   logic [15:0] year_ff, year_in;

   logic [7:0]  pc_inc;
   logic [5:0]  sec_inc;
   logic [5:0]  min_inc;
   logic [4:0]  hour_inc;
   logic [5:0]  day_inc;
   logic [3:0]  month_inc;
   logic        leap;
   logic        roll;
   logic        sp, mp, hp, ok;

   // Gregorian rule; divisibility by 25 via the inverse of 25 mod 2^16.
   function automatic logic is_leap(input logic [15:0] y);
      logic [31:0] prod;
      logic        div4;
      logic        div16;
      logic        div25;
      prod  = {16'd0, y} * 32'd23593;
      div4  = (y[1:0] == 2'd0);
      div16 = (y[3:0] == 4'd0);
      div25 = (prod[15:0] <= 16'd2621);
      return div4 && (!div25 || div16);
   endfunction

   always_comb begin
      pc_inc    = prescale_ff + 8'd1;
      sec_inc   = sec_ff + 6'd1;
      min_inc   = min_ff + 6'd1;
      hour_inc  = hour_ff + 5'd1;
      day_inc   = {1'b0, day_ff} + 6'd1;
      month_inc = month_ff + 4'd1;
      leap      = is_leap(year_ff);

      // Day roll point; a written day past month end runs on to 32.
      case (day_inc)
         6'd32:   roll = 1'b1;
         6'd31:   roll = (month_ff inside {4'd4, 4'd6, 4'd9, 4'd11});
         6'd30:   roll = (month_ff == 4'd2);
         6'd29:   roll = (month_ff == 4'd2) && !leap;
         default: roll = 1'b0;
      endcase

      prescale_in = prescale_ff;
      total_in    = total_ff;
      elapsed_in  = elapsed_ff;
      sec_in      = sec_ff;
      min_in      = min_ff;
      hour_in     = hour_ff;
      day_in      = day_ff;
      month_in    = month_ff;
      year_in     = year_ff;
      sp = 1'b0;
      mp = 1'b0;
      hp = 1'b0;
      ok = 1'b1;

      case (req.opcode)
         OP_TICK: begin
            prescale_in = pc_inc;
            total_in    = total_ff + 32'd1;
            elapsed_in  = elapsed_ff + 32'd1;
            if (pc_inc > cfg.prescale_limit) begin
               prescale_in = 8'd0;
               sp = 1'b1;
               if (!cfg.edit_hold) begin
                  if (sec_inc == 6'd60) begin
                     sec_in = 6'd0;
                     mp = 1'b1;
                     if (min_inc == 6'd60) begin
                        min_in = 6'd0;
                        hp = 1'b1;
                        if (hour_inc == 5'd24) begin
                           hour_in = 5'd0;
                           if (roll) begin
                              day_in = 5'd1;
                              if (month_inc == 4'd13) begin
                                 month_in = 4'd1;
                                 year_in  = year_ff + 16'd1;
                              end else begin
                                 month_in = month_inc;
                              end
                           end else begin
                              day_in = day_inc[4:0];
                           end
                        end else begin
                           hour_in = hour_inc;
                        end
                     end else begin
                        min_in = min_inc;
                     end
                  end else begin
                     sec_in = sec_inc;
                  end
               end
            end
         end
         OP_SET_TIME: begin
            if (req.first_value > 8'd23 || req.second_value > 8'd59 ||
                req.third_value > 8'd59) begin
               ok = 1'b0;
            end else begin
               hour_in = req.first_value[4:0];
               min_in  = req.second_value[5:0];
               sec_in  = req.third_value[5:0];
            end
         end
         OP_SET_DATE: begin
            if (req.first_value inside {[8'd1:8'd31]} &&
                req.second_value inside {[8'd1:8'd12]}) begin
               day_in   = req.first_value[4:0];
               month_in = req.second_value[3:0];
               year_in  = req.year_value;
            end else begin
               ok = 1'b0;
            end
         end
         OP_SET_ELAPSED: begin
            elapsed_in = req.elapsed_value;
         end
         default: begin
            ok = 1'b0;
         end
      endcase

      rsp.cur_seconds   = sec_in;
      rsp.cur_minutes   = min_in;
      rsp.cur_hours     = hour_in;
      rsp.cur_day       = day_in;
      rsp.cur_month     = month_in;
      rsp.cur_year      = year_in;
      rsp.second_pulse  = sp;
      rsp.minute_pulse  = mp;
      rsp.hour_pulse    = hp;
      rsp.total_ticks   = total_in;
      rsp.elapsed_ticks = elapsed_in;
      rsp.accepted      = ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= 8'd0;
         total_ff    <= 32'd0;
         elapsed_ff  <= 32'd0;
         sec_ff      <= 6'd0;
         min_ff      <= 6'd0;
         hour_ff     <= 5'd0;
         day_ff      <= 5'd0;
         month_ff    <= 4'd0;
         year_ff     <= 16'd0;
      end else if (go) begin
         prescale_ff <= prescale_in;
         total_ff    <= total_in;
         elapsed_ff  <= elapsed_in;
         sec_ff      <= sec_in;
         min_ff      <= min_in;
         hour_ff     <= hour_in;
         day_ff      <= day_in;
         month_ff    <= month_in;
         year_ff     <= year_in;
      end
   end

`ifndef SYNTHESIS
   a_hour_needs_minute: assert property (@(posedge clock) disable iff (reset)
      go && rsp.hour_pulse |-> rsp.minute_pulse && rsp.second_pulse)
      else $error("hour pulse without minute and second pulse");

   a_pulse_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      go && req.opcode != OP_TICK |-> !rsp.second_pulse)
      else $error("second pulse on a non-tick beat");

   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      sec_ff < 6'd60 && min_ff < 6'd60 && hour_ff < 5'd24 && month_ff < 4'd13)
      else $error("time or month register out of range");

   a_total_counts_ticks: assert property (@(posedge clock) disable iff (reset)
      go && req.opcode == OP_TICK |=> total_ff == $past(total_ff) + 32'd1)
      else $error("total tick count did not advance on a tick");

   a_state_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !go |=> $stable(total_ff) && $stable(sec_ff) && $stable(day_ff))
      else $error("calendar state moved without a beat");
`endif

endmodule

/* verif/rtc_calendar_counter_checker.sv */
// Checker for the RTC calendar counter: tracks the clock state and compares response beats.
`timescale 1ns / 1ps

module rtc_calendar_counter_checker
   import rtc_cal_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     outstanding
);

   // Mirror of the block's registers
   logic [7:0]  limit_q;
   logic        hold_q;
   logic [7:0]  presc_q;
   logic [31:0] ticks_total_q;
   logic [31:0] ticks_elapsed_q;
   logic [5:0]  sec_q;
   logic [5:0]  min_q;
   logic [4:0]  hour_q;
   logic [4:0]  day_q;
   logic [3:0]  month_q;
   logic [15:0] year_q;

   rsp_type pending_readings[$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < 200)
         $display("%0t rtc check: %s got 'h%0h expected 'h%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic bit is_leap(input logic [15:0] yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   // Midnight: the day rolls at its month's end, or at 32 for any month (month 0 too)
   function automatic void roll_day();
      int  d;
      int  m;
      bit  wrap;
      d = int'(day_q) + 1;
      m = int'(month_q);
      wrap = 1'b0;
      if (d == 32)
         wrap = 1'b1;
      else if (d == 31)
         wrap = (m == 4 || m == 6 || m == 9 || m == 11);
      else if (d == 30)
         wrap = (m == 2);
      else if (d == 29)
         wrap = (m == 2) && !is_leap(year_q);
      if (wrap) begin
         d = 1;
         m = m + 1;
      end
      if (m == 13) begin
         m = 1;
         year_q = year_q + 16'd1;
      end
      day_q = d[4:0];
      month_q = m[3:0];
   endfunction

   function automatic rsp_type clock_after_beat(input req_type beat);
      rsp_type r;
      int      nxt;
      r = '0;
      r.accepted = 1'b1;
      case (beat.opcode)
         OP_TICK: begin
            presc_q = presc_q + 8'd1;
            ticks_total_q = ticks_total_q + 32'd1;
            ticks_elapsed_q = ticks_elapsed_q + 32'd1;
            if (presc_q > limit_q) begin
               presc_q = '0;
               r.second_pulse = 1'b1;
               if (!hold_q) begin
                  nxt = int'(sec_q) + 1;
                  if (nxt == 60) begin
                     sec_q = '0;
                     r.minute_pulse = 1'b1;
                     nxt = int'(min_q) + 1;
                     if (nxt == 60) begin
                        min_q = '0;
                        r.hour_pulse = 1'b1;
                        nxt = int'(hour_q) + 1;
                        if (nxt == 24) begin
                           hour_q = '0;
                           roll_day();
                        end else
                           hour_q = nxt[4:0];
                     end else
                        min_q = nxt[5:0];
                  end else
                     sec_q = nxt[5:0];
               end
            end
         end
         OP_SET_TIME: begin
            if (beat.first_value > 23 || beat.second_value > 59 || beat.third_value > 59)
               r.accepted = 1'b0;
            else begin
               hour_q = beat.first_value[4:0];
               min_q = beat.second_value[5:0];
               sec_q = beat.third_value[5:0];
            end
         end
         OP_SET_DATE: begin
            if (beat.first_value < 1 || beat.first_value > 31 ||
                beat.second_value < 1 || beat.second_value > 12)
               r.accepted = 1'b0;
            else begin
               day_q = beat.first_value[4:0];
               month_q = beat.second_value[3:0];
               year_q = beat.year_value;
            end
         end
         OP_SET_ELAPSED: begin
            ticks_elapsed_q = beat.elapsed_value;
         end
      endcase
      r.cur_seconds = sec_q;
      r.cur_minutes = min_q;
      r.cur_hours = hour_q;
      r.cur_day = day_q;
      r.cur_month = month_q;
      r.cur_year = year_q;
      r.total_ticks = ticks_total_q;
      r.elapsed_ticks = ticks_elapsed_q;
      return r;
   endfunction

   task automatic compare_reading(input rsp_type got, input rsp_type want);
      if (got.cur_seconds !== want.cur_seconds)
         report_mismatch("cur_seconds", got.cur_seconds, want.cur_seconds);
      if (got.cur_minutes !== want.cur_minutes)
         report_mismatch("cur_minutes", got.cur_minutes, want.cur_minutes);
      if (got.cur_hours !== want.cur_hours)
         report_mismatch("cur_hours", got.cur_hours, want.cur_hours);
      if (got.cur_day !== want.cur_day)
         report_mismatch("cur_day", got.cur_day, want.cur_day);
      if (got.cur_month !== want.cur_month)
         report_mismatch("cur_month", got.cur_month, want.cur_month);
      if (got.cur_year !== want.cur_year)
         report_mismatch("cur_year", got.cur_year, want.cur_year);
      if (got.second_pulse !== want.second_pulse)
         report_mismatch("second_pulse", got.second_pulse, want.second_pulse);
      if (got.minute_pulse !== want.minute_pulse)
         report_mismatch("minute_pulse", got.minute_pulse, want.minute_pulse);
      if (got.hour_pulse !== want.hour_pulse)
         report_mismatch("hour_pulse", got.hour_pulse, want.hour_pulse);
      if (got.total_ticks !== want.total_ticks)
         report_mismatch("total_ticks", got.total_ticks, want.total_ticks);
      if (got.elapsed_ticks !== want.elapsed_ticks)
         report_mismatch("elapsed_ticks", got.elapsed_ticks, want.elapsed_ticks);
      if (got.accepted !== want.accepted)
         report_mismatch("accepted", got.accepted, want.accepted);
   endtask

   always @(posedge clock) begin : watch
      rsp_type oldest;
      if (reset) begin
         limit_q = PRESCALE_LIMIT_RESET;
         hold_q = 1'b0;
         presc_q = '0;
         ticks_total_q = '0;
         ticks_elapsed_q = '0;
         sec_q = '0;
         min_q = '0;
         hour_q = '0;
         day_q = '0;
         month_q = '0;
         year_q = '0;
         pending_readings.delete();
         outstanding <= 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_PRESCALE_LIMIT)
               limit_q = csr_wdata[7:0];
            else if (csr_index == CSR_EDIT_HOLD)
               hold_q = csr_wdata[0];
         end
         if (req_valid && req_ready)
            pending_readings.push_back(clock_after_beat(req_data));
         if (rsp_valid && rsp_ready) begin
            if (pending_readings.size() == 0)
               report_mismatch("response beat with nothing expected", rsp_data.total_ticks, 0);
            else begin
               oldest = pending_readings.pop_front();
               compare_reading(rsp_data, oldest);
            end
         end
         outstanding <= pending_readings.size();
      end
   end

endmodule

/* verif/rtc_calendar_counter_tb.sv */
// Testbench top for the RTC calendar counter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module rtc_calendar_counter_tb;
   import rtc_cal_pkg::*;

   localparam int LONG_HOLD = 400;
   localparam int PHASES    = 9;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int mismatches;
   int outstanding;
   int holds_wanted = 0;
   int holds_done = 0;
   bit sender_idles = 1'b1;
   bit sink_idles = 1'b1;

   rtc_calendar_counter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rtc_calendar_counter_checker watcher (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatches),
      .outstanding    (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_span();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      else if (pick < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic req_type noise_beat();
      req_type b;
      b.opcode = 2'($urandom_range(0, 3));
      b.first_value = 8'($urandom);
      b.second_value = 8'($urandom);
      b.third_value = 8'($urandom);
      b.year_value = 16'($urandom);
      b.elapsed_value = $urandom;
      return b;
   endfunction

   task automatic send_beat(input req_type b);
      int gap;
      req_data <= b;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      gap = sender_idles ? idle_span() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic tick();
      req_type b;
      b = noise_beat();
      b.opcode = OP_TICK;
      send_beat(b);
   endtask

   task automatic set_time(input logic [7:0] hr, input logic [7:0] mn, input logic [7:0] sc);
      req_type b;
      b = noise_beat();
      b.opcode = OP_SET_TIME;
      b.first_value = hr;
      b.second_value = mn;
      b.third_value = sc;
      send_beat(b);
   endtask

   task automatic set_date(input logic [7:0] dy, input logic [7:0] mo, input logic [15:0] yr);
      req_type b;
      b = noise_beat();
      b.opcode = OP_SET_DATE;
      b.first_value = dy;
      b.second_value = mo;
      b.year_value = yr;
      send_beat(b);
   endtask

   task automatic set_elapsed(input logic [31:0] count);
      req_type b;
      b = noise_beat();
      b.opcode = OP_SET_ELAPSED;
      b.elapsed_value = count;
      send_beat(b);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] limit, input logic [7:0] hold_word);
      wait_for_results();
      write_reg(CSR_PRESCALE_LIMIT, limit);
      write_reg(CSR_EDIT_HOLD, hold_word);
   endtask

   // set a date near a month end and a time just before midnight, then tick through it
   task automatic calendar_walk(output int sent);
      int          n;
      logic [7:0]  dy;
      logic [7:0]  mo;
      logic [15:0] yr;
      mo = 8'($urandom_range(1, 12));
      dy = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 31) : $urandom_range(27, 31));
      case ($urandom_range(0, 5))
         0: yr = 16'hFFFF;
         1: yr = 16'd1900;
         2: yr = 16'd2000;
         3: yr = 16'd2024;
         4: yr = 16'd2100;
         default: yr = 16'($urandom);
      endcase
      sent = 2;
      set_date(dy, mo, yr);
      set_time(8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : 23),
               8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : 59),
               8'($urandom_range(40, 59)));
      if ($urandom_range(0, 3) == 0) begin
         set_elapsed(32'hFFFF_FFFF - $urandom_range(0, 20));
         sent++;
      end
      n = $urandom_range(1, 30);
      repeat (n) tick();
      sent += n;
   endtask

   initial begin : response_sink
      int span;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (holds_done < holds_wanted) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (sink_idles && $urandom_range(0, 2) == 0) begin
            span = idle_span() + 1;
            rsp_ready <= 1'b0;
            repeat (span) @(posedge clock);
         end else begin
            span = $urandom_range(1, 8);
            rsp_ready <= 1'b1;
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      #20_000_000;
      $display("rtc_calendar_counter regression: fail");
      $finish;
   end

   initial begin : stimulus
      int         count;
      int         used;
      int         pick;
      logic [7:0] limit;
      logic [7:0] hold_word;
      bit         paused;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, prescaler only
      tick();
      configure(8'd0, 8'd0);
      // month still unset: day climbs to 31, then rolls into January
      repeat (32) begin
         set_time(23, 59, 59);
         tick();
      end
      set_elapsed(32'hFFFF_FFFF);
      tick();
      set_time(24, 0, 0);
      set_time(0, 60, 0);
      set_time(0, 0, 60);
      set_time(255, 255, 255);
      set_date(0, 1, 2000);
      set_date(32, 1, 2000);
      set_date(1, 0, 2000);
      set_date(1, 13, 2000);
      set_date(255, 255, 16'hFFFF);
      // new year's eve of the last year: wraps to year 0
      set_date(31, 12, 16'hFFFF);
      set_time(23, 59, 59);
      tick();
      // day that does not fit its month, then leap rules
      set_date(30, 2, 2023);
      set_time(23, 59, 59);
      tick();
      set_date(28, 2, 2000);
      set_time(23, 59, 59);
      tick();
      set_date(28, 2, 1900);
      set_time(23, 59, 59);
      tick();
      set_date(30, 4, 2024);
      set_time(23, 59, 59);
      tick();
      configure(8'd0, 8'd1);
      set_time(23, 59, 59);
      tick();
      tick();
      configure(8'd1, 8'd0);
      set_time(12, 59, 58);
      repeat (6) tick();

      // random phases, each under its own settings
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: limit = 8'd0;
            1: limit = 8'd1;
            3: limit = 8'd255;
            5: limit = 8'd2;
            6: limit = 8'($urandom_range(3, 254));
            default: limit = 8'd0;
         endcase
         hold_word = 8'($urandom);
         hold_word[0] = (ph == 4) || (ph == 6 && $urandom_range(0, 1) == 1);
         configure(limit, hold_word);
         sender_idles = (ph % 4 != 1);
         sink_idles = (ph % 4 != 1);

         if (ph == 3) begin
            // prescaler wraps without ever passing the limit
            repeat (300) tick();
         end else begin
            if (ph == 2) begin
               // sink stalls while the sender keeps pushing: input must back up
               sender_idles = 1'b0;
               holds_wanted++;
               repeat (60) tick();
               sender_idles = 1'b1;
            end
            count = 0;
            paused = 1'b0;
            while (count < 150) begin
               pick = $urandom_range(0, 9);
               if (pick < 7) begin
                  calendar_walk(used);
                  count += used;
               end else if (pick == 7) begin
                  set_time(8'(($urandom_range(0, 1) == 1) ? 24 : $urandom_range(0, 23)),
                           8'($urandom_range(58, 61)), 8'($urandom_range(58, 61)));
                  count++;
               end else if (pick == 8) begin
                  set_date(8'($urandom_range(0, 32)), 8'($urandom_range(0, 13)),
                           16'($urandom));
                  count++;
               end else begin
                  send_beat(noise_beat());
                  count++;
               end
               if (ph == 5 && !paused && count > 75) begin
                  paused = 1'b1;
                  wait_for_results();
                  repeat ($urandom_range(5, 30)) @(posedge clock);
               end
            end
         end
      end

      wait_for_results();
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("rtc_calendar_counter regression: pass");
      else
         $display("rtc_calendar_counter regression: fail");
      $finish;
   end

endmodule
